// File: rtl/core/dqe_pkg.sv
`timescale 1ns / 1ps

package dqe_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LABEL,
        PH_ESC1,
        PH_ESCD,
        PH_SKIP
    } phase_t;

    localparam int LABEL_MAX_DEF  = 255;
    localparam int MAX_LABELS_DEF = 64;
    localparam int QUEUE_DEPTH    = 4;

    // Output slots of one item, in the order they are written.
    localparam int SLOT_COUNT = 20;
    localparam int SLOT_HDR_SHORT = 6;
    localparam int SLOT_HDR_LAST  = 11;
    localparam int SLOT_CHAR  = 12;
    localparam int SLOT_LEN   = 13;
    localparam int SLOT_FIN   = 14;
    localparam int SLOT_FIN_LAST = 18;
    localparam int SLOT_ERR   = 19;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;

    localparam logic [14:0] HDR_LEN = 15'd12;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] mask;
        logic [15:0]           id;
        logic [14:0]           char_off;
        logic [7:0]            char_val;
        logic [14:0]           len_off;
        logic [7:0]            len_val;
        logic [14:0]           fin_off;
        logic [15:0]           qtype;
        logic [1:0]            err_code;
    } desc_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

endpackage

// File: rtl/core/dqe_front.sv
`timescale 1ns / 1ps

module dqe_front #(
    parameter int LABEL_MAX  = dqe_pkg::LABEL_MAX_DEF,
    parameter int MAX_LABELS = dqe_pkg::MAX_LABELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    char_value,
    input  logic          end_of_name,
    input  logic          any_quote,
    input  logic [15:0]   query_type,
    output dqe_pkg::desc_t desc,
    output logic          push
);
    import dqe_pkg::*;

    localparam logic [7:0] LMAX  = 8'(LABEL_MAX);
    localparam logic [6:0] LCMAX = 7'(MAX_LABELS);

    phase_t      phase_reg, phase_next;
    logic [15:0] next_id_reg, next_id_next;
    logic [7:0]  label_length_reg, label_length_next;
    logic [14:0] label_start_reg, label_start_next;
    logic [6:0]  label_count_reg, label_count_next;
    logic [9:0]  escape_value_reg, escape_value_next;
    logic [1:0]  escape_digits_reg, escape_digits_next;
    logic        quote_allowed_reg, quote_allowed_next;
    logic [15:0] type_latched_reg, type_latched_next;

    logic [1:0]  err;
    logic        close_req;
    logic        add_req;
    logic [7:0]  add_val;
    desc_t       dsc;

    always_comb
    begin
        phase_next         = phase_reg;
        next_id_next       = next_id_reg;
        label_length_next  = label_length_reg;
        label_start_next   = label_start_reg;
        label_count_next   = label_count_reg;
        escape_value_next  = escape_value_reg;
        escape_digits_next = escape_digits_reg;
        quote_allowed_next = quote_allowed_reg;
        type_latched_next  = type_latched_reg;
        err       = ST_OK;
        close_req = 1'b0;
        add_req   = 1'b0;
        add_val   = char_value;
        dsc       = '0;

        if (phase_reg == PH_SKIP)
        begin
            if (end_of_name)
            begin
                phase_next = PH_IDLE;
            end
        end
        else
        begin
            if (phase_reg == PH_IDLE)
            begin
                dsc.id             = next_id_reg;
                next_id_next       = next_id_reg + 16'd1;
                quote_allowed_next = any_quote;
                type_latched_next  = query_type;
                label_length_next  = '0;
                label_start_next   = HDR_LEN;
                label_count_next   = '0;
                escape_value_next  = '0;
                escape_digits_next = '0;
                dsc.mask[SLOT_HDR_SHORT-1:0] = '1;
                if (!end_of_name)
                begin
                    dsc.mask[SLOT_HDR_LAST:SLOT_HDR_SHORT] = '1;
                end
                phase_next = PH_LABEL;
                if (char_value == CH_NUL)
                begin
                    err = ST_INVALID;
                end
            end

            if (err == ST_OK)
            begin
                case (phase_next)
                    PH_LABEL:
                    begin
                        if (char_value == CH_DOT)
                        begin
                            close_req = 1'b1;
                        end
                        else if (char_value == CH_BSLASH)
                        begin
                            if (!quote_allowed_next)
                            begin
                                err = ST_INVALID;
                            end
                            else
                            begin
                                phase_next = PH_ESC1;
                            end
                        end
                        else
                        begin
                            if (!quote_allowed_next)
                            begin
                                if (char_value == CH_DASH)
                                begin
                                    if (label_length_next == 8'd0)
                                    begin
                                        err = ST_INVALID;
                                    end
                                end
                                else if (!is_alpha(char_value) && !is_digit(char_value))
                                begin
                                    err = ST_INVALID;
                                end
                            end
                            add_req = (err == ST_OK);
                        end
                    end
                    PH_ESC1:
                    begin
                        if (is_digit(char_value))
                        begin
                            escape_value_next  = {6'b0, char_value[3:0]};
                            escape_digits_next = 2'd1;
                            phase_next         = PH_ESCD;
                        end
                        else if (char_value == CH_NUL)
                        begin
                            err = ST_INVALID;
                        end
                        else
                        begin
                            add_req    = 1'b1;
                            phase_next = PH_LABEL;
                        end
                    end
                    PH_ESCD:
                    begin
                        if (!is_digit(char_value))
                        begin
                            err = ST_INVALID;
                        end
                        else
                        begin
                            escape_value_next = 10'({escape_value_next, 3'b000})
                                              + 10'({escape_value_next, 1'b0})
                                              + {6'b0, char_value[3:0]};
                            escape_digits_next = escape_digits_next + 2'd1;
                            if (escape_digits_next == 2'd3)
                            begin
                                if (escape_value_next >= 10'd256)
                                begin
                                    err = ST_INVALID;
                                end
                                else
                                begin
                                    add_req = 1'b1;
                                    add_val = escape_value_next[7:0];
                                end
                                escape_value_next  = '0;
                                escape_digits_next = '0;
                                phase_next         = PH_LABEL;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (add_req)
            begin
                if (label_length_next >= LMAX)
                begin
                    err = ST_INVALID;
                end
                else
                begin
                    dsc.mask[SLOT_CHAR] = 1'b1;
                    dsc.char_off = label_start_next + 15'd1 + {7'b0, label_length_next};
                    dsc.char_val = add_val;
                    label_length_next = label_length_next + 8'd1;
                end
            end

            if (err == ST_OK && end_of_name && !close_req)
            begin
                if (phase_next != PH_LABEL)
                begin
                    err = ST_INVALID;
                end
                else
                begin
                    close_req = 1'b1;
                end
            end

            if (err == ST_OK && close_req)
            begin
                if (label_length_next == 8'd0)
                begin
                    err = ST_INVALID;
                end
                else if (label_count_next >= LCMAX)
                begin
                    err = ST_TOO_MANY;
                end
                else
                begin
                    dsc.mask[SLOT_LEN] = 1'b1;
                    dsc.len_off = label_start_next;
                    dsc.len_val = label_length_next;
                    label_start_next = label_start_next + {7'b0, label_length_next} + 15'd1;
                    label_length_next = '0;
                    label_count_next  = label_count_next + 7'd1;
                end
            end

            if (err == ST_OK && end_of_name)
            begin
                dsc.mask[SLOT_FIN_LAST:SLOT_FIN] = '1;
                dsc.fin_off = label_start_next;
                dsc.qtype   = type_latched_next;
                phase_next  = PH_IDLE;
            end

            if (err != ST_OK)
            begin
                dsc.mask[SLOT_ERR] = 1'b1;
                dsc.err_code       = err;
                escape_value_next  = '0;
                escape_digits_next = '0;
                phase_next         = end_of_name ? PH_IDLE : PH_SKIP;
            end
        end
    end

    assign desc = dsc;
    assign push = accept && (dsc.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            next_id_reg       <= '0;
            label_length_reg  <= '0;
            label_start_reg   <= HDR_LEN;
            label_count_reg   <= '0;
            escape_value_reg  <= '0;
            escape_digits_reg <= '0;
            quote_allowed_reg <= 1'b0;
            type_latched_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            next_id_reg       <= next_id_next;
            label_length_reg  <= label_length_next;
            label_start_reg   <= label_start_next;
            label_count_reg   <= label_count_next;
            escape_value_reg  <= escape_value_next;
            escape_digits_reg <= escape_digits_next;
            quote_allowed_reg <= quote_allowed_next;
            type_latched_reg  <= type_latched_next;
        end
    end

endmodule

// File: rtl/core/dqe_fifo.sv
`timescale 1ns / 1ps

module dqe_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dqe_pkg::desc_t wr_data,
    input  logic           pop,
    output dqe_pkg::desc_t rd_data,
    output logic           full,
    output logic           empty
);
    import dqe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    desc_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("Queue read while empty.");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("Queue count out of range.");

endmodule

// File: rtl/core/dqe_back.sv
`timescale 1ns / 1ps

module dqe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  dqe_pkg::desc_t fifo_desc,
    input  logic           fifo_empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [14:0]    byte_offset,
    output logic [7:0]     byte_value,
    output logic           is_data,
    output logic [1:0]     status,
    output logic           done_res
);
    import dqe_pkg::*;

    desc_t                 cur_reg, cur_next;
    logic [SLOT_COUNT-1:0] mask_reg, mask_next, mask_after;
    logic                  out_valid_reg, out_valid_next;
    logic [14:0]           byte_offset_reg, byte_offset_next;
    logic [7:0]            byte_value_reg, byte_value_next;
    logic                  is_data_reg, is_data_next;
    logic [1:0]            status_reg, status_next;
    logic                  done_res_reg, done_res_next;

    logic                  advance;
    logic                  emit;
    logic [SLOT_W-1:0]     sel;
    logic [SLOT_W-1:0]     fin_idx;

    always_comb
    begin
        sel = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = SLOT_W'(i);
            end
        end

        advance = !out_valid_reg || out_ready;
        emit    = advance && (mask_reg != '0);

        mask_after = mask_reg;
        if (emit)
        begin
            mask_after[sel] = 1'b0;
        end
        pop       = !fifo_empty && (mask_after == '0);
        mask_next = pop ? fifo_desc.mask : mask_after;
        cur_next  = pop ? fifo_desc : cur_reg;

        fin_idx          = sel - SLOT_W'(SLOT_FIN);
        byte_offset_next = 15'(sel);
        byte_value_next  = 8'h00;
        is_data_next     = 1'b1;
        status_next      = ST_OK;
        done_res_next    = 1'b0;
        case (sel) inside
            [0:SLOT_HDR_LAST]:
            begin
                case (sel)
                    SLOT_W'(0): byte_value_next = cur_reg.id[15:8];
                    SLOT_W'(1): byte_value_next = cur_reg.id[7:0];
                    SLOT_W'(2): byte_value_next = 8'h01;
                    SLOT_W'(5): byte_value_next = 8'h01;
                    default:    byte_value_next = 8'h00;
                endcase
            end
            SLOT_CHAR:
            begin
                byte_offset_next = cur_reg.char_off;
                byte_value_next  = cur_reg.char_val;
            end
            SLOT_LEN:
            begin
                byte_offset_next = cur_reg.len_off;
                byte_value_next  = cur_reg.len_val;
            end
            [SLOT_FIN:SLOT_FIN_LAST]:
            begin
                byte_offset_next = cur_reg.fin_off + 15'(fin_idx);
                case (fin_idx)
                    SLOT_W'(1): byte_value_next = cur_reg.qtype[15:8];
                    SLOT_W'(2): byte_value_next = cur_reg.qtype[7:0];
                    SLOT_W'(4):
                    begin
                        byte_value_next = 8'h01;
                        done_res_next   = 1'b1;
                    end
                    default:    byte_value_next = 8'h00;
                endcase
            end
            default:
            begin
                byte_offset_next = '0;
                is_data_next     = 1'b0;
                status_next      = cur_reg.err_code;
                done_res_next    = 1'b1;
            end
        endcase

        out_valid_next = advance ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            byte_offset_reg <= byte_offset_next;
            byte_value_reg  <= byte_value_next;
            is_data_reg     <= is_data_next;
            status_reg      <= status_next;
            done_res_reg    <= done_res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_offset = byte_offset_reg;
    assign byte_value  = byte_value_reg;
    assign is_data     = is_data_reg;
    assign status      = status_reg;
    assign done_res    = done_res_reg;

    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !is_data_reg |-> status_reg != ST_OK && done_res_reg)
        else $error("Status result without an error code or end mark.");
    a_done_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_res_reg && is_data_reg |-> byte_value_reg == 8'h01)
        else $error("Final data byte of a name is not the class byte.");

endmodule

// File: rtl/core/dns_query_name_encoder_core.sv
`timescale 1ns / 1ps
// An item's first result passes through the queue, the back end's slot mask and
// its output registers. Throughput: one item per cycle while each item yields at most
// one result and out_ready holds; a name's first and last characters yield header
// and trailer bytes, written one byte per cycle, with a four-entry queue between.
// Reset (rst_n, asynchronous, active low) clears all control state and the query id.

module dns_query_name_encoder_core #(
    parameter int LABEL_MAX  = dqe_pkg::LABEL_MAX_DEF,
    parameter int MAX_LABELS = dqe_pkg::MAX_LABELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_value,
    input  logic        end_of_name,
    input  logic        any_quote,
    input  logic [15:0] query_type,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] byte_offset,
    output logic [7:0]  byte_value,
    output logic        is_data,
    output logic [1:0]  status,
    output logic        done_res
);
    import dqe_pkg::*;

    desc_t front_desc;
    desc_t queue_desc;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    logic  accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    dqe_front #(
        .LABEL_MAX  (LABEL_MAX),
        .MAX_LABELS (MAX_LABELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_value  (char_value),
        .end_of_name (end_of_name),
        .any_quote   (any_quote),
        .query_type  (query_type),
        .desc        (front_desc),
        .push        (push)
    );

    dqe_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_desc),
        .pop     (pop),
        .rd_data (queue_desc),
        .full    (full),
        .empty   (empty)
    );

    dqe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_desc   (queue_desc),
        .fifo_empty  (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_offset (byte_offset),
        .byte_value  (byte_value),
        .is_data     (is_data),
        .status      (status),
        .done_res    (done_res)
    );

endmodule
